[src/elementary_cellular_automaton_top_defines.svh]
// ----------------------------------------------------------------------------
// Elementary cellular automaton assertion macros
// Shared check macros for the automaton RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ELEMENTARY_CELLULAR_AUTOMATON_TOP_DEFINES_SVH
`define ELEMENTARY_CELLULAR_AUTOMATON_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside of reset.
`define ECA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ECA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ECA_ASSERT(lbl, prop, msg)
`define ECA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[src/eca_pkg.sv]
// ----------------------------------------------------------------------------
// Elementary cellular automaton package
// Widths, request, register and class codes, rules and the cell control bundle.
// ----------------------------------------------------------------------------
package eca_pkg;

  localparam int DEF_MAX_CELLS = 64;
  localparam int MIN_CELLS     = 3;

  localparam int ROW_W   = 64;
  localparam int TIME_W  = 16;
  localparam int CC_W    = 7;
  localparam int WC_W    = 6;
  localparam int RULE_W  = 8;
  localparam int ONES_W  = 7;
  localparam int STEPS_W = 6;
  localparam int REQ_W   = 2;
  localparam int CLS_W   = 2;
  localparam int IDX_W   = 2;
  localparam int DATA_W  = 16;

  localparam logic [REQ_W-1:0] REQ_LOAD     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STEP     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLASSIFY = 2'd2;

  localparam logic [IDX_W-1:0] REG_CELL_COUNT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_WATCH_CELL   = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_START = 2'd2;

  localparam logic [CLS_W-1:0] CLS_ALL_OFF = 2'd0;
  localparam logic [CLS_W-1:0] CLS_HALF    = 2'd1;
  localparam logic [CLS_W-1:0] CLS_ALL_ON  = 2'd2;
  localparam logic [CLS_W-1:0] CLS_MIXED   = 2'd3;

  localparam logic [RULE_W-1:0] RULE_FIRST  = 8'd184;
  localparam logic [RULE_W-1:0] RULE_SECOND = 8'd232;

  localparam logic [CC_W-1:0] CELL_COUNT_RST = 7'd64;

  typedef struct packed {
    logic              load;
    logic              step;
    logic [RULE_W-1:0] rule;
  } cell_ctrl_t;

endpackage

[src/eca_cell.sv]
// ----------------------------------------------------------------------------
// Automaton cell
// One ring cell: loads its bit or takes the rule bit of its neighborhood.
// ----------------------------------------------------------------------------
module eca_cell (
  input  logic               clk,
  input  logic               rst,
  input  eca_pkg::cell_ctrl_t ctrl,
  input  logic               en,
  input  logic               load_bit,
  input  logic               left,
  input  logic               right,
  output logic               q
);

  logic [2:0] nbr;

  assign nbr = {left, q, right};

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= 1'b0;
    end else if (ctrl.load) begin
      q <= en & load_bit;
    end else if (ctrl.step) begin
      q <= en & ctrl.rule[nbr];
    end
  end

endmodule

[src/eca_ring.sv]
// ----------------------------------------------------------------------------
// Automaton ring
// A row of cells; each cell passes its state to both neighbors every cycle.
// ----------------------------------------------------------------------------
module eca_ring #(
  parameter int MAX_CELLS = eca_pkg::DEF_MAX_CELLS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  eca_pkg::cell_ctrl_t      ctrl,
  input  logic [eca_pkg::CC_W-1:0] n,
  input  logic [MAX_CELLS-1:0]     load_row,
  output logic [MAX_CELLS-1:0]     q
);

  localparam int CW = $clog2(MAX_CELLS);

  logic [eca_pkg::CC_W-1:0] n_m1;
  logic [CW-1:0]            last_idx;
  logic                     q_last;

  assign n_m1     = n - eca_pkg::CC_W'(1);
  assign last_idx = n_m1[CW-1:0];
  assign q_last   = q[last_idx];

  for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
    logic lft;
    logic rgt;
    logic en;

    assign en = (eca_pkg::CC_W'(i) < n);

    if (i == 0) begin : g_first
      assign lft = q_last;
    end else begin : g_mid_l
      assign lft = q[i-1];
    end

    // Cells past the end of the ring are disabled, so their right input is a don't-care.
    if (i == MAX_CELLS - 1) begin : g_last
      assign rgt = q[0];
    end else begin : g_mid_r
      assign rgt = (CW'(i) == last_idx) ? q[0] : q[i+1];
    end

    eca_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .en       (en),
      .load_bit (load_row[i]),
      .left     (lft),
      .right    (rgt),
      .q        (q[i])
    );
  end

endmodule

[src/eca_popcount.sv]
// ----------------------------------------------------------------------------
// Row population count
// Two-stage registered adder tree: byte counts, then their total.
// ----------------------------------------------------------------------------
module eca_popcount #(
  parameter int MAX_CELLS = eca_pkg::DEF_MAX_CELLS
) (
  input  logic                       clk,
  input  logic [MAX_CELLS-1:0]       row,
  output logic [eca_pkg::ONES_W-1:0] ones
);

  localparam int NG = (MAX_CELLS + 7) / 8;

  logic [NG*8-1:0]           row_pad;
  logic [NG-1:0][3:0]        grp_next;
  logic [NG-1:0][3:0]        grp;
  logic [eca_pkg::ONES_W-1:0] ones_next;

  assign row_pad = (NG*8)'(row);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_next[g] = '0;
      for (int j = 0; j < 8; j++) begin
        grp_next[g] = grp_next[g] + 4'(row_pad[g*8+j]);
      end
    end
  end

  always_comb begin
    ones_next = '0;
    for (int g = 0; g < NG; g++) begin
      ones_next = ones_next + eca_pkg::ONES_W'(grp[g]);
    end
  end

  always_ff @(posedge clk) begin
    grp  <= grp_next;
    ones <= ones_next;
  end

endmodule

[src/elementary_cellular_automaton_top.sv]
// ----------------------------------------------------------------------------
// Elementary cellular automaton
// Ring of cells stepped under an 8-bit rule, with tallies and density class.
// ----------------------------------------------------------------------------
// Usage: registers are written through cfg_we/cfg_index/cfg_data while the
// block is idle. Requests arrive on in_valid/in_stall; a transfer takes place
// when in_valid is high and in_stall is low. Results leave on
// out_valid/out_stall with the same rule. A load or step request gives one
// result; a classify request gives one result per generation, and
// last_result marks the final one. Request type 3 is taken and dropped.
// Each generation runs through the cell update, the tally and byte counts,
// the total count, and the output register load; the two count steps come
// from the two-stage count tree. in_stall stays high until the last result
// of a request sits in the output register. A stall on the output holds
// the result and pauses the run in its output stage. Reset clears the row,
// time, tallies and registers (cell count 64).
// ----------------------------------------------------------------------------
`include "elementary_cellular_automaton_top_defines.svh"

module elementary_cellular_automaton_top #(
  parameter int MAX_CELLS = eca_pkg::DEF_MAX_CELLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [eca_pkg::IDX_W-1:0]   cfg_index,
  input  logic [eca_pkg::DATA_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [eca_pkg::REQ_W-1:0]   req_type,
  input  logic [eca_pkg::ROW_W-1:0]   row_in,
  input  logic [eca_pkg::RULE_W-1:0]  rule_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [eca_pkg::ROW_W-1:0]   row_out,
  output logic [eca_pkg::TIME_W-1:0]  time_now,
  output logic [eca_pkg::TIME_W-1:0]  on_tally,
  output logic [eca_pkg::TIME_W-1:0]  off_tally,
  output logic [eca_pkg::ONES_W-1:0]  ones_in_row,
  output logic [eca_pkg::CLS_W-1:0]   density_class,
  output logic                        last_result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GEN,
    S_SUM1,
    S_SUM2,
    S_EMIT
  } state_t;

  state_t state;

  logic [eca_pkg::CC_W-1:0]    cell_count;
  logic [eca_pkg::WC_W-1:0]    watch_cell;
  logic [eca_pkg::TIME_W-1:0]  window_start;

  logic [eca_pkg::REQ_W-1:0]   req_reg;
  logic [eca_pkg::ROW_W-1:0]   row_reg;
  logic [eca_pkg::RULE_W-1:0]  rule_reg;
  logic [eca_pkg::TIME_W-1:0]  step_time;
  logic [eca_pkg::TIME_W-1:0]  on_count;
  logic [eca_pkg::TIME_W-1:0]  off_count;
  logic [eca_pkg::STEPS_W-1:0] steps_left;
  logic                        phase;

  logic [eca_pkg::CC_W-1:0]    n;
  logic [eca_pkg::CC_W-1:0]    n_m2;
  logic [eca_pkg::CC_W-1:0]    n_m1;
  logic [eca_pkg::STEPS_W-1:0] first_steps;
  logic [eca_pkg::STEPS_W-1:0] second_steps;

  eca_pkg::cell_ctrl_t         ctrl;
  logic [MAX_CELLS-1:0]        cells;
  logic [MAX_CELLS-1:0]        row_mask;
  logic [eca_pkg::ROW_W-1:0]   row_ext;
  logic                        watch_bit;
  logic [eca_pkg::ONES_W-1:0]  ones;
  logic [eca_pkg::CLS_W-1:0]   cls;
  logic                        out_free;
  logic                        in_xfer;
  logic                        req_known;
  logic                        req_load;

  // Ring size clamped into the supported range.
  always_comb begin
    if (cell_count < eca_pkg::CC_W'(eca_pkg::MIN_CELLS)) begin
      n = eca_pkg::CC_W'(eca_pkg::MIN_CELLS);
    end else if (cell_count > eca_pkg::CC_W'(MAX_CELLS)) begin
      n = eca_pkg::CC_W'(MAX_CELLS);
    end else begin
      n = cell_count;
    end
  end

  assign n_m2         = n - eca_pkg::CC_W'(2);
  assign n_m1         = n - eca_pkg::CC_W'(1);
  assign first_steps  = n_m2[eca_pkg::STEPS_W:1];
  assign second_steps = n_m1[eca_pkg::STEPS_W:1];

  assign in_xfer   = in_valid && !in_stall;
  assign req_known = req_type inside {eca_pkg::REQ_LOAD, eca_pkg::REQ_STEP,
                                      eca_pkg::REQ_CLASSIFY};
  assign req_load  = (req_reg == eca_pkg::REQ_LOAD);

  always_comb begin
    for (int i = 0; i < MAX_CELLS; i++) begin
      row_mask[i] = (eca_pkg::CC_W'(i) < n);
    end
  end

  always_comb begin
    ctrl.load = (state == S_GEN) && req_load;
    ctrl.step = (state == S_GEN) && !req_load;
    if (req_reg == eca_pkg::REQ_CLASSIFY) begin
      ctrl.rule = phase ? eca_pkg::RULE_SECOND : eca_pkg::RULE_FIRST;
    end else begin
      ctrl.rule = rule_reg;
    end
  end

  eca_ring #(
    .MAX_CELLS (MAX_CELLS)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .n        (n),
    .load_row (row_reg[MAX_CELLS-1:0]),
    .q        (cells)
  );

  eca_popcount #(
    .MAX_CELLS (MAX_CELLS)
  ) u_popcount (
    .clk  (clk),
    .row  (cells),
    .ones (ones)
  );

  // A watched position past the ring reads a zero bit, so it tallies as off.
  assign row_ext   = eca_pkg::ROW_W'(cells);
  assign watch_bit = row_ext[watch_cell];

  always_comb begin
    if (ones == '0) begin
      cls = eca_pkg::CLS_ALL_OFF;
    end else if (ones == n) begin
      cls = eca_pkg::CLS_ALL_ON;
    end else if ({ones, 1'b0} == {1'b0, n}) begin
      cls = eca_pkg::CLS_HALF;
    end else begin
      cls = eca_pkg::CLS_MIXED;
    end
  end

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      cell_count   <= eca_pkg::CELL_COUNT_RST;
      watch_cell   <= '0;
      window_start <= '0;
      step_time    <= '0;
      on_count     <= '0;
      off_count    <= '0;
      steps_left   <= '0;
      phase        <= 1'b0;
      req_reg      <= eca_pkg::REQ_LOAD;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          eca_pkg::REG_CELL_COUNT:   cell_count   <= cfg_data[eca_pkg::CC_W-1:0];
          eca_pkg::REG_WATCH_CELL:   watch_cell   <= cfg_data[eca_pkg::WC_W-1:0];
          eca_pkg::REG_WINDOW_START: window_start <= cfg_data[eca_pkg::TIME_W-1:0];
          default: ;
        endcase
      end

      // The result stage refills the output register itself when it is free.
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_reg  <= req_type;
            row_reg  <= row_in;
            rule_reg <= rule_code;
            if (req_type == eca_pkg::REQ_CLASSIFY) begin
              // A ring of three cells has no first phase at all.
              if (first_steps != '0) begin
                steps_left <= first_steps;
                phase      <= 1'b0;
              end else begin
                steps_left <= second_steps;
                phase      <= 1'b1;
              end
            end
            if (req_known) begin
              state <= S_GEN;
            end
          end
        end
        S_GEN: begin
          if (req_reg == eca_pkg::REQ_LOAD) begin
            step_time  <= '0;
            on_count   <= '0;
            off_count  <= '0;
            steps_left <= '0;
          end else begin
            if (step_time != '1) begin
              step_time <= step_time + eca_pkg::TIME_W'(1);
            end
            if (req_reg == eca_pkg::REQ_CLASSIFY) begin
              steps_left <= steps_left - eca_pkg::STEPS_W'(1);
            end
          end
          state <= S_SUM1;
        end
        S_SUM1: begin
          if (step_time >= window_start) begin
            if (watch_bit) begin
              if (on_count != '1) begin
                on_count <= on_count + eca_pkg::TIME_W'(1);
              end
            end else begin
              if (off_count != '1) begin
                off_count <= off_count + eca_pkg::TIME_W'(1);
              end
            end
          end
          state <= S_SUM2;
        end
        S_SUM2: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            row_out       <= eca_pkg::ROW_W'(cells);
            time_now      <= step_time;
            on_tally      <= on_count;
            off_tally     <= off_count;
            ones_in_row   <= ones;
            density_class <= cls;
            if (req_reg != eca_pkg::REQ_CLASSIFY) begin
              last_result <= 1'b1;
              state       <= S_IDLE;
            end else if (steps_left != '0) begin
              last_result <= 1'b0;
              state       <= S_GEN;
            end else if (!phase) begin
              last_result <= 1'b0;
              phase       <= 1'b1;
              steps_left  <= second_steps;
              state       <= S_GEN;
            end else begin
              last_result <= 1'b1;
              state       <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ECA_ASSERT(a_known_req_starts, in_xfer && req_known |=> state == S_GEN, "request not started")
  `ECA_ASSERT(a_row_in_ring, state == S_SUM1 |-> (cells & ~row_mask) == '0, "stray cells set")
  `ECA_ASSERT(a_load_clr, state == S_SUM1 && req_load |-> step_time == '0, "time not cleared")
  `ECA_ASSERT(a_emit_fills_output, state == S_EMIT && out_free |=> out_valid, "result not loaded")

endmodule
